### src/lpc_pkg.sv
// Shared constants for the LIKE pattern classifier: byte codes, run classes,
// result kinds and length limits.
// No dependencies.
package lpc_pkg;

  // Longest pattern that may still take a fast path
  localparam int MaxLen = 65535;
  // Effective limit, capped at what the 16-bit length field can carry
  localparam int LenLimit = (MaxLen < 65535) ? MaxLen : 65535;

  localparam int ChW   = 8;
  localparam int LenW  = 16;
  localparam int PosW  = 17;
  localparam int KindW = 3;

  // Wildcard bytes
  localparam logic [ChW-1:0] CharPercent    = 8'd37;
  localparam logic [ChW-1:0] CharUnderscore = 8'd95;

  // Class of the previous byte
  typedef logic [1:0] class_t;
  localparam class_t ClassNone  = 2'd0;
  localparam class_t ClassWild  = 2'd1;
  localparam class_t ClassFixed = 2'd2;

  // Result kinds
  typedef logic [KindW-1:0] kind_t;
  localparam kind_t KindGeneric   = 3'd0;
  localparam kind_t KindExactlyN  = 3'd1;
  localparam kind_t KindAtLeastN  = 3'd2;
  localparam kind_t KindFixed     = 3'd3;
  localparam kind_t KindPrefix    = 3'd4;
  localparam kind_t KindSuffix    = 3'd5;

  localparam logic [PosW-1:0] PosLimit = PosW'(LenLimit);
  localparam logic [LenW-1:0] CntLimit = LenW'(LenLimit);

endpackage

### src/like_pattern_classifier.sv
// Top level of the LIKE pattern classifier: run tracking and result register.
// Depends on lpc_pkg.
//
// Takes one LIKE pattern byte per transfer and, on the transfer marked with
// in_tlast, returns one result: the fast-path kind on out_tuser and the
// reduced length on out_tdata. The run trackers update and the last byte is
// classified in the same cycle, and the result appears in the output
// register in the cycle after the last transfer.
// A new pattern may start in the very next cycle. Input is held off only
// while a result sits in the output register and out_tready is low.
// An empty pattern is one transfer with in_tuser (no byte) and in_tlast high.
module like_pattern_classifier (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] no_char
  input  logic        in_tlast,   // is_last
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] reduced_length
  output logic [2:0]  out_tuser   // [2:0] kind
);

  // Run tracking state
  logic [lpc_pkg::PosW-1:0] position_r, position_nxt, position_upd;
  lpc_pkg::class_t          prev_class_r, prev_class_nxt, prev_class_upd;
  logic [lpc_pkg::LenW-1:0] wild_start_r, wild_start_nxt, wild_start_upd;
  logic [lpc_pkg::LenW-1:0] fixed_start_r, fixed_start_nxt, fixed_start_upd;
  logic                     wild_seen_r, wild_seen_nxt, wild_seen_upd;
  logic                     fixed_seen_r, fixed_seen_nxt, fixed_seen_upd;
  logic [lpc_pkg::LenW-1:0] us_count_r, us_count_nxt, us_count_upd;
  logic                     pct_seen_r, pct_seen_nxt, pct_seen_upd;
  logic                     generic_r, generic_nxt, generic_upd;

  // Result register
  logic                     out_valid_r, out_valid_nxt;
  lpc_pkg::kind_t           out_kind_r, out_kind_nxt;
  logic [lpc_pkg::LenW-1:0] out_len_r, out_len_nxt;

  logic                     in_xfer;
  logic                     is_wild;
  lpc_pkg::class_t          cur_class;
  lpc_pkg::kind_t           res_kind;
  logic [lpc_pkg::LenW-1:0] res_len;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_xfer    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_len_r;
  assign out_tuser  = out_kind_r;

  assign is_wild   = (in_tdata == lpc_pkg::CharPercent) ||
                     (in_tdata == lpc_pkg::CharUnderscore);
  assign cur_class = is_wild ? lpc_pkg::ClassWild : lpc_pkg::ClassFixed;

  // Fold the incoming byte into the run trackers
  always_comb begin
    position_upd    = position_r;
    prev_class_upd  = prev_class_r;
    wild_start_upd  = wild_start_r;
    fixed_start_upd = fixed_start_r;
    wild_seen_upd   = wild_seen_r;
    fixed_seen_upd  = fixed_seen_r;
    us_count_upd    = us_count_r;
    pct_seen_upd    = pct_seen_r;
    generic_upd     = generic_r;
    if (in_xfer && !in_tuser) begin
      // a class change opens a new run; a second run of a class is generic
      if (cur_class != prev_class_r) begin
        if (is_wild) begin
          if (wild_seen_r) generic_upd = 1'b1;
          wild_seen_upd  = 1'b1;
          wild_start_upd = position_r[lpc_pkg::LenW-1:0];
        end else begin
          if (fixed_seen_r) generic_upd = 1'b1;
          fixed_seen_upd  = 1'b1;
          fixed_start_upd = position_r[lpc_pkg::LenW-1:0];
        end
      end
      // saturate the underscore count; beyond the limit the length check wins
      if (in_tdata == lpc_pkg::CharUnderscore && us_count_r < lpc_pkg::CntLimit) begin
        us_count_upd = us_count_r + lpc_pkg::LenW'(1);
      end
      if (in_tdata == lpc_pkg::CharPercent) pct_seen_upd = 1'b1;
      prev_class_upd = cur_class;
      if (position_r <= lpc_pkg::PosLimit) begin
        position_upd = position_r + lpc_pkg::PosW'(1);
      end
    end
  end

  // Classify the pattern as it stands after this byte
  always_comb begin
    res_kind = lpc_pkg::KindGeneric;
    res_len  = '0;
    if (generic_upd || position_upd > lpc_pkg::PosLimit) begin
      res_kind = lpc_pkg::KindGeneric;
    end else if (!fixed_seen_upd) begin
      res_kind = pct_seen_upd ? lpc_pkg::KindAtLeastN : lpc_pkg::KindExactlyN;
      res_len  = us_count_upd;
    end else if (!wild_seen_upd) begin
      res_kind = lpc_pkg::KindFixed;
      res_len  = position_upd[lpc_pkg::LenW-1:0];
    end else if (us_count_upd != '0) begin
      res_kind = lpc_pkg::KindGeneric;
    end else if (fixed_start_upd < wild_start_upd) begin
      res_kind = lpc_pkg::KindPrefix;
      res_len  = wild_start_upd;
    end else begin
      res_kind = lpc_pkg::KindSuffix;
      res_len  = position_upd[lpc_pkg::LenW-1:0] - fixed_start_upd;
    end
  end

  // Clear the trackers after the last byte; load or drain the result
  always_comb begin
    position_nxt    = position_upd;
    prev_class_nxt  = prev_class_upd;
    wild_start_nxt  = wild_start_upd;
    fixed_start_nxt = fixed_start_upd;
    wild_seen_nxt   = wild_seen_upd;
    fixed_seen_nxt  = fixed_seen_upd;
    us_count_nxt    = us_count_upd;
    pct_seen_nxt    = pct_seen_upd;
    generic_nxt     = generic_upd;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_kind_nxt    = out_kind_r;
    out_len_nxt     = out_len_r;
    if (in_xfer && in_tlast) begin
      position_nxt    = '0;
      prev_class_nxt  = lpc_pkg::ClassNone;
      wild_start_nxt  = '0;
      fixed_start_nxt = '0;
      wild_seen_nxt   = 1'b0;
      fixed_seen_nxt  = 1'b0;
      us_count_nxt    = '0;
      pct_seen_nxt    = 1'b0;
      generic_nxt     = 1'b0;
      out_valid_nxt   = 1'b1;
      out_kind_nxt    = res_kind;
      out_len_nxt     = res_len;
    end
  end

  // Control and tracker state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r    <= '0;
      prev_class_r  <= lpc_pkg::ClassNone;
      wild_start_r  <= '0;
      fixed_start_r <= '0;
      wild_seen_r   <= 1'b0;
      fixed_seen_r  <= 1'b0;
      us_count_r    <= '0;
      pct_seen_r    <= 1'b0;
      generic_r     <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      position_r    <= position_nxt;
      prev_class_r  <= prev_class_nxt;
      wild_start_r  <= wild_start_nxt;
      fixed_start_r <= fixed_start_nxt;
      wild_seen_r   <= wild_seen_nxt;
      fixed_seen_r  <= fixed_seen_nxt;
      us_count_r    <= us_count_nxt;
      pct_seen_r    <= pct_seen_nxt;
      generic_r     <= generic_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    out_kind_r <= out_kind_nxt;
    out_len_r  <= out_len_nxt;
  end

`ifndef SYNTHESIS
  // A last transfer always leaves a result and a cleared tracker behind
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && in_tlast |=> out_valid_r && position_r == '0 && !generic_r)
    else $error("last transfer did not produce a result or clear state");

  // Generic results carry no length
  a_generic_len_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_kind_r == lpc_pkg::KindGeneric |-> out_len_r == '0)
    else $error("generic result with nonzero length");

  // Position saturates one past the limit
  a_pos_saturates: assert property (@(posedge clk) disable iff (!rst_n)
    position_r <= lpc_pkg::PosLimit + lpc_pkg::PosW'(1))
    else $error("position counter ran past saturation");

  // Underscores never outnumber the bytes seen
  a_us_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, us_count_r} <= position_r)
    else $error("underscore count exceeds position");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_kind_r) && $stable(out_len_r))
    else $error("result changed while stalled");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for like_pattern_classifier: streams LIKE patterns
// in, predicts kind and reduced length per pattern, and checks every result.
// Depends on lpc_pkg and the like_pattern_classifier RTL.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandByteTarget = 1100;
  localparam int CalmTail       = 150;   // no idling once this few items remain
  localparam int StallLimit     = 2000;  // cycles without any transfer
  localparam int DrainCycles    = 20;

  typedef struct packed {
    logic [lpc_pkg::ChW-1:0] ch;
    logic                    no_char;
    logic                    last;
  } pat_item_t;

  typedef struct packed {
    lpc_pkg::kind_t           kind;
    logic [lpc_pkg::LenW-1:0] rlen;
  } pat_class_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  like_pattern_classifier uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  pat_item_t               pattern_feed[$];
  pat_class_t              expected_classes[$];
  logic [lpc_pkg::ChW-1:0] pat_buf[$];
  pat_class_t              want;
  int                      errors = 0;
  int                      in_gap = 0;
  int                      out_gap = 0;
  int                      quiet_cycles = 0;

  // Run tracker state, mirrors what the block keeps per pattern
  logic [lpc_pkg::PosW-1:0] t_pos;
  lpc_pkg::class_t          t_prev;
  logic [lpc_pkg::PosW-1:0] t_wild_start;
  logic [lpc_pkg::PosW-1:0] t_fixed_start;
  logic                     t_wild_seen;
  logic                     t_fixed_seen;
  logic [lpc_pkg::PosW-1:0] t_us_cnt;
  logic                     t_pct;
  logic                     t_generic;

  function automatic void clear_tracker();
    t_pos         = '0;
    t_prev        = lpc_pkg::ClassNone;
    t_wild_start  = '0;
    t_fixed_start = '0;
    t_wild_seen   = 1'b0;
    t_fixed_seen  = 1'b0;
    t_us_cnt      = '0;
    t_pct         = 1'b0;
    t_generic     = 1'b0;
  endfunction

  // Advance the run tracker by one accepted item; on the last item, classify
  function automatic void classify_item(input pat_item_t it);
    logic            wild;
    lpc_pkg::class_t cls;
    pat_class_t      res;
    if (!it.no_char) begin
      wild = (it.ch == lpc_pkg::CharPercent) || (it.ch == lpc_pkg::CharUnderscore);
      cls  = wild ? lpc_pkg::ClassWild : lpc_pkg::ClassFixed;
      // A new run starts; a second run of the same class spoils the fast path
      if (cls != t_prev) begin
        if (wild) begin
          if (t_wild_seen) t_generic = 1'b1;
          t_wild_seen  = 1'b1;
          t_wild_start = t_pos;
        end else begin
          if (t_fixed_seen) t_generic = 1'b1;
          t_fixed_seen  = 1'b1;
          t_fixed_start = t_pos;
        end
      end
      if (it.ch == lpc_pkg::CharUnderscore && t_us_cnt <= lpc_pkg::PosLimit) t_us_cnt++;
      if (it.ch == lpc_pkg::CharPercent) t_pct = 1'b1;
      t_prev = cls;
      if (t_pos <= lpc_pkg::PosLimit) t_pos++;
    end
    if (it.last) begin
      res.kind = lpc_pkg::KindGeneric;
      res.rlen = '0;
      if (!t_generic && t_pos <= lpc_pkg::PosLimit) begin
        if (!t_fixed_seen) begin
          res.kind = t_pct ? lpc_pkg::KindAtLeastN : lpc_pkg::KindExactlyN;
          res.rlen = t_us_cnt[lpc_pkg::LenW-1:0];
        end else if (!t_wild_seen) begin
          res.kind = lpc_pkg::KindFixed;
          res.rlen = t_pos[lpc_pkg::LenW-1:0];
        end else if (t_us_cnt == 0) begin
          if (t_fixed_start < t_wild_start) begin
            res.kind = lpc_pkg::KindPrefix;
            res.rlen = t_wild_start[lpc_pkg::LenW-1:0];
          end else begin
            res.kind = lpc_pkg::KindSuffix;
            res.rlen = lpc_pkg::LenW'(t_pos - t_fixed_start);
          end
        end
      end
      expected_classes.push_back(res);
      clear_tracker();
    end
  endfunction

  function automatic logic [lpc_pkg::ChW-1:0] fixed_byte();
    logic [lpc_pkg::ChW-1:0] b;
    do b = lpc_pkg::ChW'($urandom_range(0, 255));
    while (b == lpc_pkg::CharPercent || b == lpc_pkg::CharUnderscore);
    return b;
  endfunction

  function automatic logic [lpc_pkg::ChW-1:0] wild_byte(input bit percent_only);
    if (percent_only || $urandom_range(0, 1) == 0) return lpc_pkg::CharPercent;
    return lpc_pkg::CharUnderscore;
  endfunction

  function automatic void queue_item(input logic [lpc_pkg::ChW-1:0] ch, input logic nc,
                                     input logic last);
    pat_item_t it;
    it.ch      = ch;
    it.no_char = nc;
    it.last    = last;
    pattern_feed.push_back(it);
  endfunction

  function automatic void put_run(input bit wild, input int n, input bit percent_only);
    repeat (n) pat_buf.push_back(wild ? wild_byte(percent_only) : fixed_byte());
  endfunction

  // Queue the bytes in pat_buf as one pattern; noisy adds empty items
  function automatic void add_pattern(input bit noisy);
    int n;
    bit tail_empty;
    n = pat_buf.size();
    if (n == 0) begin
      queue_item(lpc_pkg::ChW'($urandom_range(0, 255)), 1'b1, 1'b1);
      return;
    end
    // a noisy pattern may also close with an empty last item
    tail_empty = noisy && ($urandom_range(0, 2) == 0);
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 5) == 0) begin
        queue_item(lpc_pkg::ChW'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      queue_item(pat_buf[i], 1'b0, (i == n - 1) && !tail_empty);
    end
    if (tail_empty) queue_item(lpc_pkg::ChW'($urandom_range(0, 255)), 1'b1, 1'b1);
    pat_buf.delete();
  endfunction

  // Input driver: present the next item, hold it until accepted, idle in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap    <= 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (pattern_feed.size() > 0) begin
        in_tdata  <= pattern_feed[0].ch;
        in_tuser  <= pattern_feed[0].no_char;
        in_tlast  <= pattern_feed[0].last;
        in_tvalid <= 1'b1;
        void'(pattern_feed.pop_front());
        if (pattern_feed.size() > CalmTail && $urandom_range(0, 7) == 0) begin
          in_gap <= $urandom_range(1, 15);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Output side: accept results, withdraw ready in bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap    <= 0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap    <= out_gap - 1;
    end else if (pattern_feed.size() > CalmTail && $urandom_range(0, 7) == 0) begin
      out_tready <= 1'b0;
      out_gap    <= $urandom_range(0, 14);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Monitor: compare every result transfer with the prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_classes.size() == 0) begin
        $error("unexpected result: kind %0d reduced_length %0d", out_tuser, out_tdata);
        errors++;
      end else begin
        want = expected_classes.pop_front();
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_tuser);
          errors++;
        end
        if (out_tdata !== want.rlen) begin
          $error("reduced_length: expected %0d, actual %0d", want.rlen, out_tdata);
          errors++;
        end
      end
    end
  end

  // Watchdog: stop when neither side has transferred for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int shape;
    bit noisy;
    clear_tracker();
    // Build the stimulus as a list of patterns of assorted shapes
    while (pattern_feed.size() < RandByteTarget) begin
      shape = $urandom_range(0, 9);
      noisy = ($urandom_range(0, 3) == 0);
      case (shape)
        0: pat_buf.delete();
        1: put_run(1'b1, $urandom_range(1, 8), 1'b0);
        2: repeat ($urandom_range(1, 8)) pat_buf.push_back(lpc_pkg::CharUnderscore);
        3: put_run(1'b0, $urandom_range(1, 10), 1'b0);
        4: begin
          put_run(1'b0, $urandom_range(1, 8), 1'b0);
          put_run(1'b1, $urandom_range(1, 4), 1'b1);
        end
        5: begin
          put_run(1'b1, $urandom_range(1, 4), 1'b1);
          put_run(1'b0, $urandom_range(1, 8), 1'b0);
        end
        6: begin
          put_run(1'b0, $urandom_range(1, 6), 1'b0);
          put_run(1'b1, $urandom_range(1, 4), 1'b0);
        end
        7: begin
          repeat ($urandom_range(1, 12)) begin
            pat_buf.push_back(($urandom_range(0, 2) == 0) ? wild_byte(1'b0) : fixed_byte());
          end
        end
        8: begin
          put_run(1'b0, $urandom_range(1, 4), 1'b0);
          put_run(1'b1, $urandom_range(1, 3), 1'b1);
          put_run(1'b0, $urandom_range(1, 4), 1'b0);
        end
        default: begin
          put_run(1'b0, $urandom_range(30, 80), 1'b0);
          if ($urandom_range(0, 1) == 0) put_run(1'b1, $urandom_range(1, 3), 1'b1);
        end
      endcase
      add_pattern(noisy);
    end
    // Predict every result in order
    foreach (pattern_feed[i]) classify_item(pattern_feed[i]);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for all items to go in and all results to come out
    while (pattern_feed.size() != 0 || expected_classes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

### like_pattern_classifier.f
src/lpc_pkg.sv
src/like_pattern_classifier.sv
tb/tb_top.sv
